/* rtl/interval_overlap_tracker_defines.svh */
// Assertion macros shared by the interval overlap tracker checkers
`ifndef INTERVAL_OVERLAP_TRACKER_DEFINES_SVH
`define INTERVAL_OVERLAP_TRACKER_DEFINES_SVH

// same-edge implication, off while reset is asserted
`define IOT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("iot: check failed");

// next-edge implication, off while reset is asserted
`define IOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("iot: check failed");

`endif

/* rtl/iot_pkg.sv */
// Types, constants and helper functions of the interval overlap tracker
package iot_pkg;

	localparam int POSITIONS_DEF = 1024;
	localparam int POS_W         = 10;
	localparam int COUNT_W       = 16;
	localparam int VAL_W         = 17;

	typedef logic [VAL_W-1:0] val_t;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam val_t DELTA_ADD    = VAL_W'(1);
	localparam val_t DELTA_REMOVE = '1;

	typedef struct packed {
		logic             opcode;
		logic [POS_W-1:0] left_end;
		logic [POS_W-1:0] right_end;
	} req_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] max_coverage;
		logic [COUNT_W-1:0] active_count;
		logic               disjoint_pair;
	} res_item_t;

	// one tree node: subtree maximum and the add not yet pushed down
	typedef struct packed {
		val_t mx;
		val_t pend;
	} node_t;

	// a row holds the two children of one parent
	typedef node_t [1:0] row_t;

	// walk from the root towards the leaves
	typedef struct packed {
		logic go;
		logic act_a;
		logic act_b;
		val_t push_a;
		val_t push_b;
	} down_t;

	// walk back towards the root with refreshed maxima
	typedef struct packed {
		logic go;
		val_t max_a;
		val_t max_b;
	} up_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_WALK,
		ST_FIN
	} state_t;

	function automatic val_t pick_max(val_t a, val_t b);
		return ($signed(a) >= $signed(b)) ? a : b;
	endfunction

	function automatic logic [COUNT_W-1:0] clamp_cov(val_t v);
		return v[VAL_W-1] ? '0 : v[COUNT_W-1:0];
	endfunction

endpackage

/* rtl/iot_chan_if.sv */
// Valid/ready channel carrying one payload item
interface iot_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/iot_cell.sv */
// One tree level: row store, push and add on the way down, max refresh on the way up
module iot_cell #(
	parameter int TREE_L = 10,
	parameter int LEVEL  = 1,
	parameter int CLR_W  = 9,
	parameter bit LAST   = 1'b0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [TREE_L-1:0]      ql,
	input  logic [TREE_L-1:0]      qr,
	input  iot_pkg::val_t          delta,
	input  logic                   clear_en,
	input  logic [CLR_W-1:0]       clear_row,
	input  iot_pkg::down_t         down_in,
	output iot_pkg::down_t         down_out,
	input  iot_pkg::up_t           up_in,
	output iot_pkg::up_t           up_out
);

	localparam int S     = TREE_L - LEVEL;
	localparam int ROW_W = (LEVEL > 1) ? LEVEL - 1 : 1;
	localparam int ROWS  = 1 << ROW_W;
	localparam logic [TREE_L-1:0] LOW_MASK = TREE_L'((1 << S) - 1);
	localparam logic [TREE_L-1:0] BIT_S    = TREE_L'(1 << S);
	localparam logic [TREE_L-1:0] HI_CLR   = ~(LOW_MASK | BIT_S);

	iot_pkg::row_t mem [ROWS];
	iot_pkg::row_t rd_q [2];
	iot_pkg::row_t held_q [2];
	iot_pkg::row_t nxt [2];
	iot_pkg::row_t fin [2];

	logic [TREE_L-1:0] base [2];
	logic [TREE_L-1:0] ql_sh;
	logic [TREE_L-1:0] qr_sh;
	logic [ROW_W-1:0]  row_a;
	logic [ROW_W-1:0]  row_b;
	logic              same;
	logic              ba;
	logic              bb;
	iot_pkg::val_t     push [2];
	logic [1:0]        part_m [2];
	iot_pkg::val_t     carry [2][2];

	logic              act_a_q;
	logic              act_b_q;
	logic              pa_q;
	logic              pb_q;
	logic              done_q;
	logic              wr_b_q;
	logic              up_go;

	logic              dn_go_q;
	logic              dn_act_a_q;
	logic              dn_act_b_q;
	iot_pkg::val_t     dn_push_a_q;
	iot_pkg::val_t     dn_push_b_q;
	logic              up_go_q;
	iot_pkg::val_t     up_max_a_q;
	iot_pkg::val_t     up_max_b_q;

	logic              wr_en;
	logic [ROW_W-1:0]  wr_addr;
	iot_pkg::row_t     wr_data;

	assign ql_sh   = ql >> (S + 1);
	assign qr_sh   = qr >> (S + 1);
	assign row_a   = ql_sh[ROW_W-1:0];
	assign row_b   = qr_sh[ROW_W-1:0];
	assign base[0] = ql & HI_CLR;
	assign base[1] = qr & HI_CLR;
	assign same    = (base[0] == base[1]);
	assign ba      = ql[S];
	assign bb      = qr[S];
	assign push[0] = down_in.push_a;
	assign push[1] = down_in.push_b;

	// classify each child, push the parent's pending add into it and apply the delta
	always_comb begin
		logic [TREE_L-1:0] lo;
		logic [TREE_L-1:0] hi;
		logic              full;
		logic              ovl;
		iot_pkg::val_t     add;
		iot_pkg::val_t     sum;
		for (int s = 0; s < 2; s++) begin
			for (int b = 0; b < 2; b++) begin
				lo   = base[s] | ((b == 1) ? BIT_S : '0);
				hi   = lo | LOW_MASK;
				full = (ql <= lo) && (hi <= qr);
				ovl  = (lo <= qr) && (ql <= hi);
				add  = full ? delta : '0;
				sum  = rd_q[s][b].pend + push[s];
				part_m[s][b]   = ovl && !full;
				carry[s][b]    = sum;
				nxt[s][b].mx   = rd_q[s][b].mx + push[s] + add;
				nxt[s][b].pend = (ovl && !full) ? '0 : sum + add;
			end
		end
	end

	assign up_go = up_in.go | (LAST & done_q);

	// drop in the refreshed maxima of the partial children
	always_comb begin
		for (int s = 0; s < 2; s++) begin
			for (int b = 0; b < 2; b++) begin
				fin[s][b] = held_q[s][b];
				if (pa_q && (int'(ba) == b) && ((s == 0) || same)) begin
					fin[s][b].mx = up_in.max_a;
				end
				if (pb_q && (int'(bb) == b) && ((s == 1) || same)) begin
					fin[s][b].mx = up_in.max_b;
				end
			end
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = row_a;
		wr_data = fin[0];
		priority if (clear_en) begin
			wr_en   = 1'b1;
			wr_addr = clear_row[ROW_W-1:0];
			wr_data = '0;
		end else if (up_go && act_a_q) begin
			wr_en   = 1'b1;
		end else if (wr_b_q) begin
			wr_en   = 1'b1;
			wr_addr = row_b;
			wr_data = held_q[1];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q[0] <= mem[row_a];
		rd_q[1] <= mem[row_b];
	end

	always_ff @(posedge clk) begin
		if (down_in.go) begin
			held_q[0]   <= nxt[0];
			held_q[1]   <= nxt[1];
			dn_push_a_q <= carry[0][ba];
			dn_push_b_q <= carry[1][bb];
		end else if (up_go) begin
			held_q[1]   <= fin[1];
		end
		if (up_go) begin
			up_max_a_q <= iot_pkg::pick_max(fin[0][0].mx, fin[0][1].mx);
			up_max_b_q <= iot_pkg::pick_max(fin[1][0].mx, fin[1][1].mx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_a_q    <= 1'b0;
			act_b_q    <= 1'b0;
			pa_q       <= 1'b0;
			pb_q       <= 1'b0;
			done_q     <= 1'b0;
			wr_b_q     <= 1'b0;
			dn_go_q    <= 1'b0;
			dn_act_a_q <= 1'b0;
			dn_act_b_q <= 1'b0;
			up_go_q    <= 1'b0;
		end else begin
			dn_go_q <= down_in.go;
			done_q  <= down_in.go;
			up_go_q <= up_go;
			wr_b_q  <= up_go && act_b_q && !same;
			if (down_in.go) begin
				act_a_q    <= down_in.act_a;
				act_b_q    <= down_in.act_b;
				pa_q       <= down_in.act_a && part_m[0][ba];
				pb_q       <= down_in.act_b && part_m[1][bb];
				dn_act_a_q <= down_in.act_a && part_m[0][ba];
				dn_act_b_q <= down_in.act_b && part_m[1][bb];
			end
		end
	end

	assign down_out.go     = dn_go_q;
	assign down_out.act_a  = dn_act_a_q;
	assign down_out.act_b  = dn_act_b_q;
	assign down_out.push_a = dn_push_a_q;
	assign down_out.push_b = dn_push_b_q;
	assign up_out.go       = up_go_q;
	assign up_out.max_a    = up_max_a_q;
	assign up_out.max_b    = up_max_b_q;

endmodule

/* rtl/interval_overlap_tracker.sv */
// Top level of the interval overlap tracker: root node, count, control and the cell chain
//
//  channel  | way | payload                                    | handshake
//  request  | in  | opcode, left_end, right_end                | valid / ready
//  result   | out | max_coverage, active_count, disjoint_pair  | valid / ready
//
// A request is accepted in IDLE and passes START, WALK and FIN; its result is loaded on
// leaving FIN, and the next request is taken back in IDLE. The down walk crosses one level
// cell per cycle, the up walk likewise.
// An empty, out-of-range or whole-range interval skips the walk: it goes from START
// straight to FIN, which loads its result.
// After reset a clearing pass zeroes the level memories with request.ready low.
// A result waiting on result.ready does not stop the next request being accepted;
// only that request's result holds until the output register frees.
module interval_overlap_tracker #(
	parameter int POSITIONS = iot_pkg::POSITIONS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	iot_chan_if.sink       request,
	iot_chan_if.source     result
);

	localparam int TREE_L   = $clog2(POSITIONS);
	localparam int CLR_W    = (TREE_L > 1) ? TREE_L - 1 : 1;
	localparam int LAST_POS = POSITIONS - 1;

	iot_pkg::state_t    state_q;
	iot_pkg::state_t    state_d;
	logic [CLR_W-1:0]   clr_q;
	logic [TREE_L-1:0]  ql_q;
	logic [TREE_L-1:0]  qr_q;
	logic               upd_q;
	logic               op_q;
	iot_pkg::val_t      root_max_q;
	iot_pkg::val_t      root_pend_q;
	iot_pkg::val_t      count_q;
	iot_pkg::val_t      delta;
	logic               res_valid_q;
	iot_pkg::res_item_t res_q;
	logic               dn_go_q;
	iot_pkg::val_t      dn_push_q;

	logic               ready;
	logic               accept;
	logic               clear_en;
	logic               clear_last;
	logic               start;
	logic               root_full;
	logic               walk_done;
	logic               load;
	logic               upd_d;
	logic [TREE_L-1:0]  qr_clip;

	iot_pkg::down_t     dn [TREE_L+1];
	iot_pkg::up_t       upw [1:TREE_L+1];

	assign delta      = (op_q == iot_pkg::OP_REMOVE) ? iot_pkg::DELTA_REMOVE : iot_pkg::DELTA_ADD;
	assign root_full  = (ql_q == '0) && (qr_q == '1);
	assign clear_last = (clr_q == '1);
	assign accept     = request.valid && ready;
	assign upd_d      = (request.payload.left_end <= request.payload.right_end)
		&& (int'(request.payload.left_end) <= LAST_POS);
	assign qr_clip    = (int'(request.payload.right_end) > LAST_POS) ? TREE_L'(LAST_POS)
		: TREE_L'(request.payload.right_end);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iot_pkg::ST_CLEAR: if (clear_last) state_d = iot_pkg::ST_IDLE;
			iot_pkg::ST_IDLE:  if (request.valid) state_d = iot_pkg::ST_START;
			iot_pkg::ST_START: begin
				if (upd_q && !root_full) state_d = iot_pkg::ST_WALK;
				else state_d = iot_pkg::ST_FIN;
			end
			iot_pkg::ST_WALK:  if (upw[1].go) state_d = iot_pkg::ST_FIN;
			iot_pkg::ST_FIN:   if (!res_valid_q || result.ready) state_d = iot_pkg::ST_IDLE;
			default:           state_d = iot_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		ready     = 1'b0;
		clear_en  = 1'b0;
		start     = 1'b0;
		walk_done = 1'b0;
		load      = 1'b0;
		unique case (state_q)
			iot_pkg::ST_CLEAR: clear_en  = 1'b1;
			iot_pkg::ST_IDLE:  ready     = 1'b1;
			iot_pkg::ST_START: start     = 1'b1;
			iot_pkg::ST_WALK:  walk_done = upw[1].go;
			iot_pkg::ST_FIN:   load      = !res_valid_q || result.ready;
			default:           clear_en  = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= request.payload.opcode;
			ql_q  <= TREE_L'(request.payload.left_end);
			qr_q  <= qr_clip;
			upd_q <= upd_d;
		end
		if (start) begin
			dn_push_q <= root_pend_q;
		end
		if (load) begin
			res_q.max_coverage  <= iot_pkg::clamp_cov(root_max_q);
			res_q.active_count  <= iot_pkg::clamp_cov(count_q);
			res_q.disjoint_pair <= $signed(count_q) > $signed(root_max_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iot_pkg::ST_CLEAR;
			clr_q       <= '0;
			root_max_q  <= '0;
			root_pend_q <= '0;
			count_q     <= '0;
			dn_go_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			dn_go_q     <= 1'b0;
			res_valid_q <= load || (res_valid_q && !result.ready);
			if (clear_en) begin
				clr_q <= clr_q + 1'b1;
			end
			if (start) begin
				count_q <= count_q + delta;
				if (upd_q && root_full) begin
					root_max_q  <= root_max_q + delta;
					root_pend_q <= root_pend_q + delta;
				end else if (upd_q) begin
					// hand the root's pending add to its children and walk down
					dn_go_q     <= 1'b1;
					root_pend_q <= '0;
				end
			end
			if (walk_done) begin
				root_max_q <= upw[1].max_a;
			end
		end
	end

	assign dn[0].go     = dn_go_q;
	assign dn[0].act_a  = 1'b1;
	assign dn[0].act_b  = 1'b1;
	assign dn[0].push_a = dn_push_q;
	assign dn[0].push_b = dn_push_q;
	assign upw[TREE_L+1] = '0;

	for (genvar j = 1; j <= TREE_L; j++) begin : g_cell
		iot_cell #(
			.TREE_L (TREE_L),
			.LEVEL  (j),
			.CLR_W  (CLR_W),
			.LAST   (j == TREE_L)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ql        (ql_q),
			.qr        (qr_q),
			.delta     (delta),
			.clear_en  (clear_en),
			.clear_row (clr_q),
			.down_in   (dn[j-1]),
			.down_out  (dn[j]),
			.up_in     (upw[j+1]),
			.up_out    (upw[j])
		);
	end

	assign request.ready  = ready;
	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

endmodule

/* rtl/iot_checker.sv */
// Port-level checks of the interval overlap tracker and their bind
`include "interval_overlap_tracker_defines.svh"

module iot_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               res_valid,
	input logic               res_ready,
	input iot_pkg::res_item_t res_payload
);

	`IOT_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	`IOT_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(res_payload))
	`IOT_ASSERT_NEXT(a_one_request, clk, arst_n, req_valid && req_ready, !req_ready)
	`IOT_ASSERT_NEXT(a_no_early_result, clk, arst_n, req_valid && req_ready, !$rose(res_valid))
	`IOT_ASSERT_NOW(a_flag_order, clk, arst_n, res_valid && res_payload.disjoint_pair,
		res_payload.active_count >= res_payload.max_coverage)

endmodule

bind interval_overlap_tracker iot_checker u_iot_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (request.valid),
	.req_ready   (request.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_payload (result.payload)
);

/* verif/iot_result_checker.sv */
// Coverage predictor and result checker for the interval overlap tracker
module iot_result_checker (
	input  logic  clk,
	input  logic  arst_n,
	iot_chan_if   request,
	iot_chan_if   result,
	output int    outstanding,
	output int    failures
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SPAN      = iot_pkg::POSITIONS_DEF;
	localparam int NODES     = 4 * SPAN;
	localparam int SHOWN_MAX = 10;

	typedef struct {
		int unsigned node;
		int unsigned lo;
		int unsigned hi;
		bit          post;
	} frame_t;

	iot_pkg::val_t      cov_max  [NODES];
	iot_pkg::val_t      cov_pend [NODES];
	iot_pkg::val_t      live_total;
	iot_pkg::res_item_t expected_res[$];

	function automatic iot_pkg::val_t higher_of(iot_pkg::val_t a, iot_pkg::val_t b);
		return ($signed(a) >= $signed(b)) ? a : b;
	endfunction

	function automatic logic [iot_pkg::COUNT_W-1:0] floor_zero(iot_pkg::val_t v);
		return v[iot_pkg::VAL_W-1] ? '0 : v[iot_pkg::COUNT_W-1:0];
	endfunction

	function automatic void bump_node(int unsigned k, iot_pkg::val_t d);
		if (k < NODES) begin
			cov_max[k]  = cov_max[k] + d;
			cov_pend[k] = cov_pend[k] + d;
		end
	endfunction

	// lazy range add, walked with an explicit stack instead of recursion
	function automatic void add_range(int unsigned ql, int unsigned qr, iot_pkg::val_t d);
		frame_t      walk[$];
		frame_t      f;
		frame_t      nf;
		int unsigned mid;
		nf = '{1, 0, SPAN - 1, 1'b0};
		walk.insert(walk.size(), nf);
		while (walk.size() > 0) begin
			f = walk.pop_back();
			if (f.post) begin
				if (2 * f.node + 1 < NODES)
					cov_max[f.node] = higher_of(cov_max[2 * f.node], cov_max[2 * f.node + 1]);
				continue;
			end
			if (f.node >= NODES || qr < f.lo || f.hi < ql)
				continue;
			if (ql <= f.lo && f.hi <= qr) begin
				bump_node(f.node, d);
				continue;
			end
			mid = (f.lo + f.hi) >> 1;
			bump_node(2 * f.node, cov_pend[f.node]);
			bump_node(2 * f.node + 1, cov_pend[f.node]);
			cov_pend[f.node] = '0;
			nf = '{f.node, f.lo, f.hi, 1'b1};
			walk.insert(walk.size(), nf);
			nf = '{2 * f.node + 1, mid + 1, f.hi, 1'b0};
			walk.insert(walk.size(), nf);
			nf = '{2 * f.node, f.lo, mid, 1'b0};
			walk.insert(walk.size(), nf);
		end
	endfunction

	function automatic iot_pkg::res_item_t track_request(iot_pkg::req_item_t req);
		iot_pkg::res_item_t r;
		iot_pkg::val_t      d;
		d = (req.opcode == iot_pkg::OP_REMOVE) ? iot_pkg::DELTA_REMOVE : iot_pkg::DELTA_ADD;
		if (req.left_end <= req.right_end)
			add_range(req.left_end, req.right_end, d);
		live_total        = live_total + d;
		r.max_coverage    = floor_zero(cov_max[1]);
		r.active_count    = floor_zero(live_total);
		r.disjoint_pair   = ($signed(live_total) > $signed(cov_max[1]));
		return r;
	endfunction

	function automatic void note_failure(string what);
		failures++;
		if (failures <= SHOWN_MAX)
			$display("%0t: %s", $realtime, what);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		iot_pkg::res_item_t want;
		iot_pkg::res_item_t got;
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				cov_max[i]  = '0;
				cov_pend[i] = '0;
			end
			live_total = '0;
			expected_res.delete();
			outstanding = 0;
			failures    = 0;
		end else begin
			// take the result first: it always belongs to an older request
			if (result.valid && result.ready) begin
				got = result.payload;
				if (expected_res.size() == 0) begin
					note_failure($sformatf("result with nothing pending: cov=%0d count=%0d flag=%0b",
						got.max_coverage, got.active_count, got.disjoint_pair));
				end else begin
					want = expected_res.pop_front();
					if (got.max_coverage !== want.max_coverage
							|| got.active_count !== want.active_count
							|| got.disjoint_pair !== want.disjoint_pair)
						note_failure($sformatf(
							"mismatch: expected cov=%0d count=%0d flag=%0b, got cov=%0d count=%0d flag=%0b",
							want.max_coverage, want.active_count, want.disjoint_pair,
							got.max_coverage, got.active_count, got.disjoint_pair));
				end
			end
			if (request.valid && request.ready)
				expected_res.insert(expected_res.size(), track_request(request.payload));
			outstanding = expected_res.size();
		end
	end

endmodule

/* verif/tb_interval_overlap_tracker.sv */
// Stimulus, clocking and verdict for the interval overlap tracker
module tb_interval_overlap_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  SPAN        = iot_pkg::POSITIONS_DEF;
	localparam int  POS_W       = iot_pkg::POS_W;
	localparam int  STALL_LIMIT = 4000;
	localparam int  LIVE_CAP    = 48;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(SPAN - 1);

	typedef struct packed {
		logic [POS_W-1:0] lo_pos;
		logic [POS_W-1:0] hi_pos;
	} span_t;

	logic  clk;
	logic  arst_n;
	int    outstanding;
	int    failures;
	int    send_idle_pct;
	int    recv_idle_pct;
	int    quiet_cycles;
	span_t live_spans[$];

	iot_chan_if #(.payload_t(iot_pkg::req_item_t)) req_if ();
	iot_chan_if #(.payload_t(iot_pkg::res_item_t)) res_if ();

	interval_overlap_tracker #(.POSITIONS(SPAN)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_if),
		.result  (res_if)
	);

	iot_result_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.request     (req_if),
		.result      (res_if),
		.outstanding (outstanding),
		.failures    (failures)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: stall at random on each falling edge
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_if.ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_request(input logic op, input logic [POS_W-1:0] l,
			input logic [POS_W-1:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.payload = '{opcode: op, left_end: l, right_end: r};
		req_if.valid   = 1'b1;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold the request channel until every result is back
	task automatic drain_results();
		req_if.valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	function automatic span_t pick_span();
		span_t       s;
		int unsigned a;
		int unsigned b;
		case ($urandom_range(3))
			0: begin
				a = $urandom_range(SPAN - 1);
				b = a;
			end
			1: begin
				a = $urandom_range(SPAN - 1);
				b = a + $urandom_range(16);
				if (b > SPAN - 1)
					b = SPAN - 1;
			end
			2: begin
				a = $urandom_range(SPAN - 1);
				b = $urandom_range(SPAN - 1);
				if (a > b) begin
					a = a ^ b;
					b = a ^ b;
					a = a ^ b;
				end
			end
			default: begin
				if ($urandom_range(1)) begin
					a = 0;
					b = $urandom_range(SPAN - 1);
				end else begin
					a = $urandom_range(SPAN - 1);
					b = SPAN - 1;
				end
			end
		endcase
		s.lo_pos = POS_W'(a);
		s.hi_pos = POS_W'(b);
		return s;
	endfunction

	// mostly matched add/remove traffic, with reversed and unmatched requests as noise
	task automatic random_request();
		span_t       s;
		int unsigned roll;
		int unsigned idx;
		roll = $urandom_range(99);
		if (roll < 15) begin
			s = pick_span();
			case ($urandom_range(2))
				0: send_request(iot_pkg::OP_ADD, s.hi_pos | POS_W'(1), s.lo_pos & ~POS_W'(1));
				1: send_request(iot_pkg::OP_REMOVE, s.hi_pos | POS_W'(1), s.lo_pos & ~POS_W'(1));
				default: send_request(iot_pkg::OP_REMOVE, s.lo_pos, s.hi_pos);
			endcase
		end else if (live_spans.size() == 0 || (roll < 58 && live_spans.size() < LIVE_CAP)) begin
			s = pick_span();
			live_spans.insert(live_spans.size(), s);
			send_request(iot_pkg::OP_ADD, s.lo_pos, s.hi_pos);
		end else begin
			idx = $urandom_range(live_spans.size() - 1);
			s   = live_spans[idx];
			live_spans.delete(idx);
			send_request(iot_pkg::OP_REMOVE, s.lo_pos, s.hi_pos);
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		send_idle_pct  = 29;
		recv_idle_pct  = 83;
		quiet_cycles   = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed: whole range, end points, reversed, disjoint, unmatched removal
		send_request(iot_pkg::OP_ADD, '0, POS_LAST);
		send_request(iot_pkg::OP_ADD, '0, '0);
		send_request(iot_pkg::OP_ADD, POS_LAST, POS_LAST);
		send_request(iot_pkg::OP_ADD, POS_LAST, '0);
		send_request(iot_pkg::OP_REMOVE, POS_LAST, '0);
		send_request(iot_pkg::OP_REMOVE, '0, '0);
		send_request(iot_pkg::OP_REMOVE, POS_LAST, POS_LAST);
		send_request(iot_pkg::OP_ADD, '0, 10'd511);
		send_request(iot_pkg::OP_ADD, 10'd512, POS_LAST);
		send_request(iot_pkg::OP_REMOVE, '0, POS_LAST);
		send_request(iot_pkg::OP_REMOVE, '0, 10'd511);
		send_request(iot_pkg::OP_REMOVE, 10'd512, POS_LAST);
		send_request(iot_pkg::OP_REMOVE, 10'd300, 10'd700);
		send_request(iot_pkg::OP_REMOVE, 10'd513, 10'd512);
		send_request(iot_pkg::OP_ADD, 10'd513, 10'd512);
		send_request(iot_pkg::OP_ADD, 10'd300, 10'd700);
		send_request(iot_pkg::OP_ADD, 10'd5, 10'd5);
		send_request(iot_pkg::OP_ADD, 10'd6, 10'd6);
		send_request(iot_pkg::OP_ADD, 10'd1, 10'd1022);
		send_request(iot_pkg::OP_REMOVE, 10'd5, 10'd5);
		send_request(iot_pkg::OP_REMOVE, 10'd6, 10'd6);
		send_request(iot_pkg::OP_REMOVE, 10'd1, 10'd1022);
		send_request(iot_pkg::OP_ADD, 10'h155, 10'h2AA);
		send_request(iot_pkg::OP_REMOVE, 10'h155, 10'h2AA);
		drain_results();

		repeat (600) random_request();
		drain_results();

		send_idle_pct = 83;
		recv_idle_pct = 29;
		repeat (600) random_request();
		drain_results();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (500) random_request();
		drain_results();

		repeat (40) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/iot_pkg.sv
rtl/iot_chan_if.sv
rtl/iot_cell.sv
rtl/interval_overlap_tracker.sv
rtl/iot_checker.sv
verif/iot_result_checker.sv
verif/tb_interval_overlap_tracker.sv
